// ===== design/efpw_pkg.sv =====
// ============================================================================
// efpw_pkg: shared types and constants of the ellipse fill pixel writer
// Widths of coordinates, squares and address words, the multiplier operation
// codes, the controller states and the command/status bundles.
// ============================================================================
package efpw_pkg;

    // Address and coordinate widths
    localparam int ADDR_BITS  = 32;
    localparam int COORD_BITS = 16;
    localparam int COLOR_W    = 32;
    localparam int STEP_W     = 16;

    // Derived widths: half size, signed grid position, squares, products
    localparam int HALF_W = COORD_BITS - 1;
    localparam int POS_W  = COORD_BITS + 1;
    localparam int SQ_W   = 2 * HALF_W;
    localparam int TERM_W = 2 * SQ_W;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Operation codes of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_WW,
        MUL_HH,
        MUL_AREA,
        MUL_COL_SQ,
        MUL_COL_TERM,
        MUL_ROW_SQ,
        MUL_ROW_TERM
    } t_mul_op;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WSQ,
        S_HSQ,
        S_AREA,
        S_PLAIN,
        S_COL_SQ,
        S_COL_TERM,
        S_PIXEL,
        S_ROW_SQ,
        S_ROW_TERM
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        t_mul_op mul_op;
        logic    emit_plain;
        logic    emit_pixel;
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic busy;
        logic out_free;
        logic row_wrap;
    } t_dp_status;

    // Magnitude of a signed grid position; |pos| never exceeds a half size
    function automatic logic [HALF_W-1:0] abs_pos(input logic signed [POS_W-1:0] v);
        logic [POS_W-1:0] mag;
        mag = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
        return mag[HALF_W-1:0];
    endfunction

endpackage

// ===== design/efpw_in_if.sv =====
// ============================================================================
// efpw_in_if: input channel of the ellipse fill pixel writer
// Valid/ready handshake carrying one start or advance item.
// ============================================================================
interface efpw_in_if;
    import efpw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [COORD_BITS-1:0]    left_x;
    logic [COORD_BITS-1:0]    right_x;
    logic [COORD_BITS-1:0]    top_y;
    logic [COORD_BITS-1:0]    bottom_y;
    logic [COLOR_W-1:0]       fill_color;
    logic [ADDR_BITS-1:0]     start_address;
    logic signed [STEP_W-1:0] column_step;
    logic signed [STEP_W-1:0] row_step;

    modport source (
        output valid, mode, left_x, right_x, top_y, bottom_y,
               fill_color, start_address, column_step, row_step,
        input  ready
    );

    modport sink (
        input  valid, mode, left_x, right_x, top_y, bottom_y,
               fill_color, start_address, column_step, row_step,
        output ready
    );
endinterface

// ===== design/efpw_out_if.sv =====
// ============================================================================
// efpw_out_if: result channel of the ellipse fill pixel writer
// Valid/ready handshake carrying one pixel write result.
// ============================================================================
interface efpw_out_if;
    import efpw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 write_valid;
    logic [ADDR_BITS-1:0] write_address;
    logic [COLOR_W-1:0]   write_data;
    logic                 fill_done;

    modport source (
        output valid, write_valid, write_address, write_data, fill_done,
        input  ready
    );

    modport sink (
        input  valid, write_valid, write_address, write_data, fill_done,
        output ready
    );
endinterface

// ===== design/ellipse_fill_pixel_writer.sv =====
// ============================================================================
// ellipse_fill_pixel_writer: filled-ellipse rasterizer issuing pixel writes
// Top level joining the sequencer and the datapath.
// ============================================================================
// One item is in work at a time. A start item forms three products (w*w,
// h*h and their product) before its result, an advance inside a row forms
// |x|*|x|, then times h*h, then the compare, and an advance that ends a row
// also forms the next row term |y|*|y|*w*w after its result. An advance
// while no fill runs forms no product. This order follows from the single
// 32x32 multiplier that all products share. The result sits in an output
// register; a stalled result channel holds back work only when the next
// result is due. A reversed or empty box returns fill_done at once and
// draws nothing.
module ellipse_fill_pixel_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    efpw_in_if.sink     i_in,
    efpw_out_if.source  o_out
);
    import efpw_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Sequencer
    efpw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath
    efpw_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

// ===== design/efpw_ctrl.sv =====
// ============================================================================
// efpw_ctrl: sequencer of the ellipse fill pixel writer
// Takes one item at a time and steps the datapath through the multiplies,
// the result transfer and the row update.
// ============================================================================
module efpw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_mode,
    output logic                  o_in_ready,
    input  efpw_pkg::t_dp_status  i_status,
    output efpw_pkg::t_ctrl_cmd   o_cmd
);
    import efpw_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_fire;

    assign in_fire = i_in_valid && (r_state == S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_mode) begin
                        n_state = S_WSQ;
                    end else if (i_status.busy) begin
                        n_state = S_COL_SQ;
                    end else begin
                        n_state = S_PLAIN;
                    end
                end
            end
            S_WSQ:      n_state = S_HSQ;
            S_HSQ:      n_state = S_AREA;
            S_AREA:     n_state = S_PLAIN;
            S_PLAIN: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_COL_SQ:   n_state = S_COL_TERM;
            S_COL_TERM: n_state = S_PIXEL;
            S_PIXEL: begin
                if (i_status.out_free) begin
                    n_state = i_status.row_wrap ? S_ROW_SQ : S_IDLE;
                end
            end
            S_ROW_SQ:   n_state = S_ROW_TERM;
            S_ROW_TERM: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.mul_op     = MUL_NONE;
        o_cmd.emit_plain = 1'b0;
        o_cmd.emit_pixel = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = in_fire && i_in_mode;
            end
            S_WSQ:      o_cmd.mul_op = MUL_WW;
            S_HSQ:      o_cmd.mul_op = MUL_HH;
            S_AREA:     o_cmd.mul_op = MUL_AREA;
            S_PLAIN:    o_cmd.emit_plain = i_status.out_free;
            S_COL_SQ:   o_cmd.mul_op = MUL_COL_SQ;
            S_COL_TERM: o_cmd.mul_op = MUL_COL_TERM;
            S_PIXEL:    o_cmd.emit_pixel = i_status.out_free;
            S_ROW_SQ:   o_cmd.mul_op = MUL_ROW_SQ;
            S_ROW_TERM: o_cmd.mul_op = MUL_ROW_TERM;
            default:    o_cmd.mul_op = MUL_NONE;
        endcase
    end

endmodule

// ===== design/efpw_datapath.sv =====
// ============================================================================
// efpw_datapath: fill state, shared multiplier and result register
// Holds the box terms, the grid position and addresses, runs one multiply per
// command and drives the result channel from an output register.
// ============================================================================
module efpw_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  efpw_pkg::t_ctrl_cmd  i_cmd,
    output efpw_pkg::t_dp_status o_status,
    efpw_in_if.sink              i_in,
    efpw_out_if.source           o_out
);
    import efpw_pkg::*;

    // Fill state
    logic                     r_busy;
    logic [HALF_W-1:0]        r_half_w;
    logic [HALF_W-1:0]        r_half_h;
    logic signed [POS_W-1:0]  r_col_pos;
    logic signed [POS_W-1:0]  r_row_pos;
    logic [SQ_W-1:0]          r_width_sq;
    logic [SQ_W-1:0]          r_height_sq;
    logic [TERM_W-1:0]        r_area;
    logic [TERM_W-1:0]        r_row_term;
    logic [TERM_W-1:0]        r_prod;
    logic [ADDR_BITS-1:0]     r_row_addr;
    logic [ADDR_BITS-1:0]     r_pix_addr;
    logic [COLOR_W-1:0]       r_color;
    logic [STEP_W-1:0]        r_col_step;
    logic [STEP_W-1:0]        r_row_step;

    // Result register
    logic                     r_out_valid;
    logic                     r_out_write_valid;
    logic [ADDR_BITS-1:0]     r_out_addr;
    logic [COLOR_W-1:0]       r_out_data;
    logic                     r_out_done;

    // Half sizes of the incoming box, floor of the difference over two
    logic signed [COORD_BITS:0] diff_w;
    logic signed [COORD_BITS:0] diff_h;
    logic                       ok_w;
    logic                       ok_h;
    logic [HALF_W-1:0]          new_half_w;
    logic [HALF_W-1:0]          new_half_h;

    assign diff_w = $signed({1'b0, i_in.right_x}) - $signed({1'b0, i_in.left_x});
    assign diff_h = $signed({1'b0, i_in.bottom_y}) - $signed({1'b0, i_in.top_y});
    assign ok_w   = !diff_w[COORD_BITS] && (diff_w[COORD_BITS-1:1] != '0);
    assign ok_h   = !diff_h[COORD_BITS] && (diff_h[COORD_BITS-1:1] != '0);
    assign new_half_w = ok_w ? diff_w[COORD_BITS-1:1] : '0;
    assign new_half_h = ok_h ? diff_h[COORD_BITS-1:1] : '0;

    // Grid stepping
    logic signed [POS_W-1:0] half_w_s;
    logic signed [POS_W-1:0] half_h_s;
    logic signed [POS_W-1:0] col_next;
    logic signed [POS_W-1:0] row_next;
    logic                    row_wrap;
    logic                    busy_next;
    logic [ADDR_BITS-1:0]    col_step_ext;
    logic [ADDR_BITS-1:0]    row_step_ext;
    logic [ADDR_BITS-1:0]    row_addr_next;

    assign half_w_s  = $signed({2'b00, r_half_w});
    assign half_h_s  = $signed({2'b00, r_half_h});
    assign col_next  = r_col_pos + $signed(POS_W'(1));
    assign row_next  = r_row_pos + $signed(POS_W'(1));
    assign row_wrap  = (col_next >= half_w_s);
    assign busy_next = !(row_wrap && (row_next >= half_h_s));

    assign col_step_ext  = {{(ADDR_BITS-STEP_W){r_col_step[STEP_W-1]}}, r_col_step};
    assign row_step_ext  = {{(ADDR_BITS-STEP_W){r_row_step[STEP_W-1]}}, r_row_step};
    assign row_addr_next = r_row_addr + row_step_ext;

    // Inside test: column term plus row term below the area term
    logic [TERM_W:0] lhs_sum;
    logic            in_ellipse;

    assign lhs_sum    = {1'b0, r_prod} + {1'b0, r_row_term};
    assign in_ellipse = lhs_sum < {1'b0, r_area};

    // Shared multiplier operands
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_op)
            MUL_WW: begin
                mul_a = MUL_W'(r_half_w);
                mul_b = MUL_W'(r_half_w);
            end
            MUL_HH: begin
                mul_a = MUL_W'(r_half_h);
                mul_b = MUL_W'(r_half_h);
            end
            MUL_AREA: begin
                mul_a = MUL_W'(r_width_sq);
                mul_b = MUL_W'(r_height_sq);
            end
            MUL_COL_SQ: begin
                mul_a = MUL_W'(abs_pos(r_col_pos));
                mul_b = MUL_W'(abs_pos(r_col_pos));
            end
            MUL_COL_TERM: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = MUL_W'(r_height_sq);
            end
            MUL_ROW_SQ: begin
                mul_a = MUL_W'(abs_pos(r_row_pos));
                mul_b = MUL_W'(abs_pos(r_row_pos));
            end
            MUL_ROW_TERM: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = MUL_W'(r_width_sq);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.load) begin
            r_busy <= ok_w && ok_h;
        end else if (i_cmd.emit_pixel) begin
            r_busy <= busy_next;
        end
    end

    // Clear the fill on reset, latch a new fill, step the grid after a pixel result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w   <= '0;
            r_half_h   <= '0;
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_color    <= '0;
            r_row_addr <= '0;
            r_pix_addr <= '0;
            r_col_step <= '0;
            r_row_step <= '0;
        end else if (i_cmd.load) begin
            r_half_w   <= new_half_w;
            r_half_h   <= new_half_h;
            r_col_pos  <= -$signed({2'b00, new_half_w});
            r_row_pos  <= -$signed({2'b00, new_half_h});
            r_color    <= i_in.fill_color;
            r_row_addr <= i_in.start_address;
            r_pix_addr <= i_in.start_address;
            r_col_step <= i_in.column_step;
            r_row_step <= i_in.row_step;
        end else if (i_cmd.emit_pixel) begin
            if (row_wrap) begin
                r_col_pos  <= -half_w_s;
                r_row_pos  <= row_next;
                r_row_addr <= row_addr_next;
                r_pix_addr <= row_addr_next;
            end else begin
                r_col_pos  <= col_next;
                r_pix_addr <= r_pix_addr + col_step_ext;
            end
        end
    end

    // Route the product to its destination
    always_ff @(posedge i_clk) begin
        case (i_cmd.mul_op)
            MUL_WW:       r_width_sq  <= mul_p[SQ_W-1:0];
            MUL_HH:       r_height_sq <= mul_p[SQ_W-1:0];
            MUL_AREA: begin
                // first row sits at |y| = h, so its row term equals the area term
                r_area     <= mul_p[TERM_W-1:0];
                r_row_term <= mul_p[TERM_W-1:0];
            end
            MUL_COL_SQ:   r_prod      <= mul_p[TERM_W-1:0];
            MUL_COL_TERM: r_prod      <= mul_p[TERM_W-1:0];
            MUL_ROW_SQ:   r_prod      <= mul_p[TERM_W-1:0];
            MUL_ROW_TERM: r_row_term  <= mul_p[TERM_W-1:0];
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_plain || i_cmd.emit_pixel) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_plain) begin
            r_out_write_valid <= 1'b0;
            r_out_addr        <= r_pix_addr;
            r_out_data        <= r_color;
            r_out_done        <= !r_busy;
        end else if (i_cmd.emit_pixel) begin
            r_out_write_valid <= in_ellipse;
            r_out_addr        <= r_pix_addr;
            r_out_data        <= r_color;
            r_out_done        <= !busy_next;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.write_valid   = r_out_write_valid;
    assign o_out.write_address = r_out_addr;
    assign o_out.write_data    = r_out_data;
    assign o_out.fill_done     = r_out_done;

    assign o_status.busy     = r_busy;
    assign o_status.out_free = !r_out_valid || o_out.ready;
    assign o_status.row_wrap = row_wrap;

endmodule

// ===== design/efpw_checker.sv =====
// ============================================================================
// efpw_checker: port-level checks of the ellipse fill pixel writer
// Watches the two channels of the top level over time.
// ============================================================================
module efpw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_write_valid,
    input logic [efpw_pkg::ADDR_BITS-1:0] i_out_write_address,
    input logic [efpw_pkg::COLOR_W-1:0]   i_out_write_data,
    input logic                           i_out_fill_done
);
    import efpw_pkg::*;

    // A stalled result stays offered
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_write_valid) && $stable(i_out_write_address) &&
            $stable(i_out_write_data) && $stable(i_out_fill_done))
        else $error("result payload changed while stalled");

    // One item at a time: input closes right after a transfer
    a_in_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is in work");

    // Reset leaves no result pending
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind ellipse_fill_pixel_writer efpw_checker u_efpw_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_write_valid   (o_out.write_valid),
    .i_out_write_address (o_out.write_address),
    .i_out_write_data    (o_out.write_data),
    .i_out_fill_done     (o_out.fill_done)
);

// ===== tb/ellipse_fill_pixel_writer_test.sv =====
// ============================================================================
// ellipse_fill_pixel_writer_test: self-checking bench of the ellipse filler
// Feeds start and advance commands through the input channel, predicts every
// pixel write with a cycle-free raster model and compares each result field
// by field. Covers empty and reversed boxes, the largest box, address wrap,
// signed strides, restarts in mid fill and long back-pressure stalls.
// ============================================================================
module ellipse_fill_pixel_writer_test;
    import efpw_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_CMDS    = 1550;
    localparam int HOLD_AT        = 600;
    localparam int HOLD_CYCLES    = 300;
    localparam int PAUSE_EVERY    = 15;

    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_START   = 1'b1;

    typedef struct {
        logic                     mode;
        logic [COORD_BITS-1:0]    left_x;
        logic [COORD_BITS-1:0]    right_x;
        logic [COORD_BITS-1:0]    top_y;
        logic [COORD_BITS-1:0]    bottom_y;
        logic [COLOR_W-1:0]       fill_color;
        logic [ADDR_BITS-1:0]     start_address;
        logic signed [STEP_W-1:0] column_step;
        logic signed [STEP_W-1:0] row_step;
        bit                       wait_empty;
    } t_fill_cmd;

    typedef struct {
        logic                 write_valid;
        logic [ADDR_BITS-1:0] write_address;
        logic [COLOR_W-1:0]   write_data;
        logic                 fill_done;
    } t_pixel_write;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    efpw_in_if  in_ch ();
    efpw_out_if out_ch ();

    ellipse_fill_pixel_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Raster state of the predictor
    bit                       ras_busy      = 1'b0;
    int                       ras_half_w    = 0;
    int                       ras_half_h    = 0;
    int                       ras_x         = 0;
    int                       ras_y         = 0;
    longint unsigned          ras_w_sq      = 0;
    longint unsigned          ras_h_sq      = 0;
    longint unsigned          ras_area      = 0;
    longint unsigned          ras_row_term  = 0;
    logic [ADDR_BITS-1:0]     ras_row_addr  = '0;
    logic [ADDR_BITS-1:0]     ras_pix_addr  = '0;
    logic [COLOR_W-1:0]       ras_color     = '0;
    logic signed [STEP_W-1:0] ras_col_step  = '0;
    logic signed [STEP_W-1:0] ras_row_step  = '0;

    t_fill_cmd    cmd_queue[$];
    t_pixel_write pixel_expect[$];
    t_fill_cmd    cur_cmd;

    int n_errors     = 0;
    int n_cmds_sent  = 0;
    int n_results    = 0;
    int n_starts     = 0;
    int n_fills      = 0;
    int n_writes     = 0;
    int total_cmds   = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int quiet_cycles = 0;

    function automatic longint unsigned sq_mag(input int v);
        longint unsigned a;
        a = (v < 0) ? longint'(-v) : longint'(v);
        return a * a;
    endfunction

    // floor((hi - lo) / 2), negative for a reversed box
    function automatic int half_span(input logic [COORD_BITS-1:0] lo,
                                     input logic [COORD_BITS-1:0] hi);
        int d;
        d = int'(hi) - int'(lo);
        return d >>> 1;
    endfunction

    // Advance the raster model by one command and return the write it causes
    function automatic t_pixel_write raster_step(input t_fill_cmd c);
        t_pixel_write    r;
        int              hw;
        int              hh;
        longint unsigned col_term;
        if (c.mode == MODE_START) begin
            hw           = half_span(c.left_x, c.right_x);
            hh           = half_span(c.top_y, c.bottom_y);
            ras_busy     = (hw > 0) && (hh > 0);
            ras_half_w   = (hw > 0) ? hw : 0;
            ras_half_h   = (hh > 0) ? hh : 0;
            ras_w_sq     = sq_mag(ras_half_w);
            ras_h_sq     = sq_mag(ras_half_h);
            ras_area     = ras_w_sq * ras_h_sq;
            ras_x        = -ras_half_w;
            ras_y        = -ras_half_h;
            ras_row_term = sq_mag(ras_y) * ras_w_sq;
            ras_color    = c.fill_color;
            ras_row_addr = c.start_address;
            ras_pix_addr = c.start_address;
            ras_col_step = c.column_step;
            ras_row_step = c.row_step;
            n_starts++;
            r = '{1'b0, ras_pix_addr, ras_color, !ras_busy};
            return r;
        end
        // Advance with no fill running: report the held address and color
        if (!ras_busy) begin
            r = '{1'b0, ras_pix_addr, ras_color, 1'b1};
            return r;
        end
        col_term        = sq_mag(ras_x) * ras_h_sq;
        r.write_valid   = (col_term + ras_row_term) < ras_area;
        r.write_address = ras_pix_addr;
        r.write_data    = ras_color;
        if (r.write_valid)
            n_writes++;
        ras_pix_addr = ras_pix_addr + ADDR_BITS'(ras_col_step);
        ras_x++;
        // Wrap to the next row at the end of a row
        if (ras_x >= ras_half_w) begin
            ras_x        = -ras_half_w;
            ras_y++;
            ras_row_addr = ras_row_addr + ADDR_BITS'(ras_row_step);
            ras_pix_addr = ras_row_addr;
            ras_row_term = sq_mag(ras_y) * ras_w_sq;
            if (ras_y >= ras_half_h) begin
                ras_busy = 1'b0;
                n_fills++;
            end
        end
        r.fill_done = !ras_busy;
        return r;
    endfunction

    function automatic t_fill_cmd random_cmd(input logic mode);
        t_fill_cmd c;
        c.mode          = mode;
        c.left_x        = 16'($urandom);
        c.right_x       = 16'($urandom);
        c.top_y         = 16'($urandom);
        c.bottom_y      = 16'($urandom);
        c.fill_color    = $urandom;
        c.start_address = $urandom;
        c.column_step   = 16'($urandom);
        c.row_step      = 16'($urandom);
        c.wait_empty    = 1'b0;
        return c;
    endfunction

    function automatic t_fill_cmd make_start(
        input logic [COORD_BITS-1:0] l, r, t, b,
        input logic [COLOR_W-1:0] color,
        input logic [ADDR_BITS-1:0] addr,
        input logic signed [STEP_W-1:0] cs, rs
    );
        t_fill_cmd c;
        c = '{MODE_START, l, r, t, b, color, addr, cs, rs, 1'b0};
        return c;
    endfunction

    task automatic queue_advances(input int n);
        repeat (n) cmd_queue.push_back(random_cmd(MODE_ADVANCE));
    endtask

    // Small box walked to the end, now and then cut short by the next start
    task automatic queue_small_fill(input bit pause);
        t_fill_cmd c;
        int        hw;
        int        hh;
        int        steps;
        hw = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
        hh = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
        c            = random_cmd(MODE_START);
        c.left_x     = 16'($urandom_range(0, 65535 - 2 * hw - 1));
        c.right_x    = 16'(c.left_x + 2 * hw + $urandom_range(0, 1));
        c.top_y      = 16'($urandom_range(0, 65535 - 2 * hh - 1));
        c.bottom_y   = 16'(c.top_y + 2 * hh + $urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            c.column_step = 16'sd4;
        c.wait_empty = pause;
        cmd_queue.push_back(c);
        steps = 4 * hw * hh;
        if ($urandom_range(0, 9) == 0)
            steps = $urandom_range(0, steps - 1);
        queue_advances(steps + $urandom_range(0, 2));
    endtask

    // Idle length: mostly none or short, a few long, with gap-free stretches
    function automatic int pick_gap(input int n);
        int r;
        if (n % 400 < 60)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, got_v);
            n_errors++;
        end
    endfunction

    // Hold reset at the start of the run, then release it
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Command driver: predict on each transfer, then offer the next command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                pixel_expect.push_back(raster_step(cur_cmd));
                n_cmds_sent++;
                send_gap = pick_gap(n_cmds_sent);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (cmd_queue.size() != 0 &&
                             (!cmd_queue[0].wait_empty || pixel_expect.size() == 0)) begin
                    cur_cmd                = cmd_queue.pop_front();
                    in_ch.valid           <= 1'b1;
                    in_ch.mode            <= cur_cmd.mode;
                    in_ch.left_x          <= cur_cmd.left_x;
                    in_ch.right_x         <= cur_cmd.right_x;
                    in_ch.top_y           <= cur_cmd.top_y;
                    in_ch.bottom_y        <= cur_cmd.bottom_y;
                    in_ch.fill_color      <= cur_cmd.fill_color;
                    in_ch.start_address   <= cur_cmd.start_address;
                    in_ch.column_step     <= cur_cmd.column_step;
                    in_ch.row_step        <= cur_cmd.row_step;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer, then pick the next ready level
    always @(posedge i_clk) begin
        t_pixel_write want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (pixel_expect.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual addr 0x%0h",
                             $time, out_ch.write_address);
                    n_errors++;
                end else begin
                    want = pixel_expect.pop_front();
                    check_field("write_valid", want.write_valid, out_ch.write_valid);
                    check_field("write_address", want.write_address, out_ch.write_address);
                    check_field("write_data", want.write_data, out_ch.write_data);
                    check_field("fill_done", want.fill_done, out_ch.fill_done);
                end
            end
            // Hold off once for a long stretch so the block backs up
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && n_results >= HOLD_AT) begin
                hold_done     = 1'b1;
                hold_left     = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(n_results);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pixel_expect.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run
    initial begin
        t_fill_cmd c;
        int        pick;
        int        n_seq;
        in_ch.valid         = 1'b0;
        in_ch.mode          = MODE_ADVANCE;
        in_ch.left_x        = '0;
        in_ch.right_x       = '0;
        in_ch.top_y         = '0;
        in_ch.bottom_y      = '0;
        in_ch.fill_color    = '0;
        in_ch.start_address = '0;
        in_ch.column_step   = '0;
        in_ch.row_step      = '0;
        out_ch.ready        = 1'b0;

        // Directed: idle advance, empty and reversed boxes, largest box,
        // restart in mid fill, address wrap and extreme strides
        queue_advances(1);
        cmd_queue.push_back(make_start(16'd7, 16'd7, 16'd0, 16'd12, 32'h1234_5678,
                                       32'h0000_0100, 16'sd4, 16'sd64));
        cmd_queue.push_back(make_start(16'd100, 16'd50, 16'd9, 16'd3, 32'hDEAD_BEEF,
                                       32'h8000_0000, 16'sd4, 16'sd640));
        queue_advances(1);
        cmd_queue.push_back(make_start(16'd200, 16'd201, 16'd10, 16'd50, 32'h0F0F_0F0F,
                                       32'h0000_2000, 16'sd4, 16'sd256));
        cmd_queue.push_back(make_start(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFC, 16'sh8000, 16'sh7FFF));
        queue_advances(3);
        cmd_queue.push_back(make_start(16'd10, 16'd13, 16'd20, 16'd22, 32'h0000_0000,
                                       32'hFFFF_FFF8, 16'sd4, 16'sh8000));
        queue_advances(5);
        cmd_queue.push_back(make_start(16'd65531, 16'hFFFF, 16'd65533, 16'hFFFF,
                                       32'hA5A5_5A5A, 32'h0000_0000, 16'shFFFF, 16'sh7FFF));
        queue_advances(8);

        // Random: mostly complete small fills, some wild starts and noise
        n_seq = 0;
        while (cmd_queue.size() < 24 + RANDOM_CMDS) begin
            pick = $urandom_range(0, 99);
            n_seq++;
            if (pick < 70) begin
                queue_small_fill(n_seq % PAUSE_EVERY == 0);
            end else if (pick < 85) begin
                c = random_cmd(MODE_START);
                cmd_queue.push_back(c);
                queue_advances($urandom_range(0, 4));
            end else begin
                queue_advances($urandom_range(1, 3));
            end
        end
        total_cmds = cmd_queue.size();

        while (n_cmds_sent < total_cmds)
            @(posedge i_clk);
        while (pixel_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands with %0d fill starts, %0d fills walked to the end.",
                 n_cmds_sent, n_starts, n_fills);
        $display("Checked %0d results, %0d of them pixel writes, %0d mismatches.",
                 n_results, n_writes, n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/efpw_pkg.sv
design/efpw_in_if.sv
design/efpw_out_if.sv
design/efpw_ctrl.sv
design/efpw_datapath.sv
design/ellipse_fill_pixel_writer.sv
design/efpw_checker.sv
tb/ellipse_fill_pixel_writer_test.sv
